FILE: rtl/core/one_shot_timer_queue_unit_defines.svh
// Assertion macros for the one-shot timer queue unit.
// Used by the port checker; relies on clk and arst_n in the using scope.
`ifndef ONE_SHOT_TIMER_QUEUE_UNIT_DEFINES_SVH
`define ONE_SHOT_TIMER_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define OSTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ostq_pkg.sv
// Shared types and constants of the one-shot timer queue unit.
// No dependencies.
`timescale 1ns / 1ps
package ostq_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	localparam logic [19:0] NS_PER_MS   = 20'd1000000;
	localparam logic [19:0] NS_ROUND_UP = 20'd999999;
	localparam logic [30:0] WAIT_MAX    = 31'h7FFFFFFF;
	localparam logic [31:0] WAIT_NONE   = 32'hFFFFFFFF;
	localparam logic [62:0] TIME_MAX    = 63'h7FFFFFFFFFFFFFFF;
	localparam logic [63:0] DIV_LIMIT   = 64'd2147483648000000;
	localparam logic [45:0] DIV_RECIP   = 46'd36893488147420;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_REM  = 2'd1,
		OP_QRY  = 2'd2,
		OP_DISP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_EXP  = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SC_ID    = 2'd0,
		SC_REM   = 2'd1,
		SC_MIN   = 2'd2,
		SC_SWEEP = 2'd3
	} scan_mode_t;

	typedef enum logic [2:0] {
		RES_FULL  = 3'd0,
		RES_ADD   = 3'd1,
		RES_DONE  = 3'd2,
		RES_MISS  = 3'd3,
		RES_EMPTY = 3'd4,
		RES_WAIT  = 3'd5,
		RES_EXP   = 3'd6
	} res_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       id_adv;
		logic       add_commit;
		logic       free_sel;
		logic       div_start;
		logic       emit;
		res_sel_t   res_sel;
		logic       res_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic expired;
		logic full;
		logic div_done;
		logic out_free;
	} ctl_sts_t;

endpackage

FILE: rtl/core/ostq_if.sv
// Request and response channel interfaces of the timer queue unit.
// Depends on nothing but fixed field widths.
`timescale 1ns / 1ps
interface ostq_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic        [62:0] now_time;
	logic signed [31:0] delay_ms;
	logic        [30:0] target_id;

	modport source (output valid, cmd, now_time, delay_ms, target_id, input ready);
	modport sink (input valid, cmd, now_time, delay_ms, target_id, output ready);
endinterface

interface ostq_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic        [30:0] timer_id;
	logic signed [31:0] wait_ms;
	logic               last;

	modport source (output valid, status, timer_id, wait_ms, last, input ready);
	modport sink (input valid, status, timer_id, wait_ms, last, output ready);
endinterface

FILE: rtl/core/one_shot_timer_queue_unit.sv
// Top level of the one-shot timer queue unit.
// Depends on ostq_pkg, ostq_if, ostq_ctrl, ostq_dp.
//
// Holds up to CAPACITY one-shot timers in three slot RAMs (deadline, ID,
// insertion rank) that are walked one slot per cycle through their read
// port. One command word is taken at a time. Add: one walk per ID tried
// (one when the next ID is free), then the slot is written. Remove: one walk
// to find the ID and one to renumber ranks. Query: one walk for the earliest
// deadline and a three-step multiply by the reciprocal of one million.
// Dispatch (at most MAX_RESULTS timers): per expired timer one search walk
// and one rank walk, plus a final search walk unless the limit is reached.
// Each response word leaves through an output register and waits there
// until taken.
`timescale 1ns / 1ps
module one_shot_timer_queue_unit #(
	parameter int CAPACITY = ostq_pkg::CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	ostq_req_if.sink   req,
	ostq_rsp_if.source rsp
);
	import ostq_pkg::*;

	ctl_cmd_t cmd_c;
	ctl_sts_t sts;

	ostq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.op(req.cmd),
		.sts(sts),
		.cmd_c(cmd_c)
	);

	ostq_dp #(.CAP(CAPACITY)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_c(cmd_c),
		.sts(sts),
		.now_time(req.now_time),
		.delay_ms(req.delay_ms),
		.target_id(req.target_id),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.status(rsp.status),
		.timer_id(rsp.timer_id),
		.wait_ms(rsp.wait_ms),
		.last(rsp.last)
	);
endmodule

FILE: rtl/core/ostq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ostq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/ostq_dp.sv
// Datapath of the timer queue: slot RAMs, valid bits, scan engine,
// deadline arithmetic, ceiling divider and response register. Uses ostq_pkg, ostq_ram.
`timescale 1ns / 1ps
module ostq_dp #(
	parameter int CAP = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ostq_pkg::ctl_cmd_t cmd_c,
	output ostq_pkg::ctl_sts_t sts,
	input  logic        [62:0] now_time,
	input  logic signed [31:0] delay_ms,
	input  logic        [30:0] target_id,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic        [1:0]  status,
	output logic        [30:0] timer_id,
	output logic signed [31:0] wait_ms,
	output logic               last
);
	import ostq_pkg::*;

	localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CW = $clog2(CAP + 1);

	logic [62:0]    now_q;
	logic [31:0]    delay_q;
	logic [30:0]    target_q;
	logic [30:0]    delay_pos;
	logic [50:0]    prod_s1;
	logic [63:0]    sum;
	logic [62:0]    dl_s2;

	logic [CAP-1:0] valid_q;
	logic [CW-1:0]  count_q;
	logic [30:0]    next_id_q;
	logic [30:0]    added_id_q;
	logic [30:0]    pend_id_q;

	logic           issuing_q;
	logic [IW-1:0]  addr_q;
	logic           live_s1;
	logic           last_s1;
	logic           vld_s1;
	logic [IW-1:0]  idx_s1;
	logic           done_q;
	scan_mode_t     mode_q;

	logic           hit_q;
	logic [IW-1:0]  sel_slot_q;
	logic [IW-1:0]  sel_rank_q;
	logic [62:0]    sel_dl_q;
	logic [30:0]    sel_id_q;
	logic           free_ok_q;
	logic [IW-1:0]  free_slot_q;
	logic [IW-1:0]  sw_rank_q;

	logic [62:0]    dl_rd;
	logic [30:0]    id_rd;
	logic [IW-1:0]  rk_rd;
	logic           sw_we;
	logic           rk_we;
	logic [IW-1:0]  rk_waddr;
	logic [IW-1:0]  rk_wdata;
	logic           better;

	logic           div_chk_q;
	logic           div_run_q;
	logic           div_done_q;
	logic           le_q;
	logic [63:0]    rem_q;
	logic [44:0]    mul_src_q;
	logic [90:0]    acc_q;
	logic [1:0]     cnt_q;
	logic [31:0]    wait_q;
	logic [60:0]    part;
	logic [90:0]    acc_nx;

	logic           out_free;

	// deadline: now + delay * 1e6, saturated
	assign delay_pos = delay_q[31] ? '0 : delay_q[30:0];
	assign sum       = {1'b0, now_q} + {13'd0, prod_s1};

	always_ff @(posedge clk) begin
		if (cmd_c.load_in) begin
			now_q    <= now_time;
			delay_q  <= delay_ms;
			target_q <= target_id;
		end
		prod_s1 <= delay_pos * NS_PER_MS;
		dl_s2   <= sum[63] ? TIME_MAX : sum[62:0];
	end

	// slot stores
	assign sw_we    = live_s1 && (mode_q == SC_SWEEP) && vld_s1 && (rk_rd > sw_rank_q);
	assign rk_we    = cmd_c.add_commit || sw_we;
	assign rk_waddr = cmd_c.add_commit ? free_slot_q : idx_s1;
	assign rk_wdata = cmd_c.add_commit ? count_q[IW-1:0] : rk_rd - 1'b1;

	ostq_ram #(.WIDTH(63), .DEPTH(CAP)) u_dl_ram (
		.clk(clk), .we(cmd_c.add_commit), .waddr(free_slot_q), .wdata(dl_s2),
		.raddr(addr_q), .rdata(dl_rd)
	);

	ostq_ram #(.WIDTH(31), .DEPTH(CAP)) u_id_ram (
		.clk(clk), .we(cmd_c.add_commit), .waddr(free_slot_q), .wdata(next_id_q),
		.raddr(addr_q), .rdata(id_rd)
	);

	ostq_ram #(.WIDTH(IW), .DEPTH(CAP)) u_rk_ram (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(addr_q), .rdata(rk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			next_id_q <= '0;
		end else begin
			if (cmd_c.add_commit) begin
				valid_q[free_slot_q] <= 1'b1;
				count_q              <= count_q + 1'b1;
				next_id_q            <= next_id_q + 1'b1;
			end else if (cmd_c.id_adv) begin
				next_id_q <= next_id_q + 1'b1;
			end else if (cmd_c.free_sel) begin
				valid_q[sel_slot_q] <= 1'b0;
				count_q             <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.add_commit) begin
			added_id_q <= next_id_q;
		end
		if (cmd_c.free_sel) begin
			pend_id_q <= sel_id_q;
			sw_rank_q <= sel_rank_q;
		end
	end

	// scan engine: one slot per cycle through the read ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			addr_q    <= '0;
			live_s1   <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			mode_q    <= SC_ID;
		end else begin
			live_s1 <= issuing_q;
			last_s1 <= issuing_q && (addr_q == IW'(CAP - 1));
			done_q  <= live_s1 && last_s1;
			if (cmd_c.scan_start) begin
				issuing_q <= 1'b1;
				addr_q    <= '0;
				mode_q    <= cmd_c.scan_mode;
			end else if (issuing_q) begin
				if (addr_q == IW'(CAP - 1)) begin
					issuing_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[addr_q];
		idx_s1 <= addr_q;
	end

	assign better = !hit_q || (dl_rd < sel_dl_q) || ((dl_rd == sel_dl_q) && (rk_rd < sel_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd_c.scan_start) begin
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (live_s1) begin
			case (mode_q)
				SC_ID: begin
					if (vld_s1 && (id_rd == next_id_q)) begin
						hit_q <= 1'b1;
					end
					if (!vld_s1 && !free_ok_q) begin
						free_ok_q <= 1'b1;
					end
				end
				SC_REM: begin
					if (vld_s1 && !hit_q && (id_rd == target_q)) begin
						hit_q <= 1'b1;
					end
				end
				SC_MIN: begin
					if (vld_s1 && better) begin
						hit_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (live_s1) begin
			if ((mode_q == SC_ID) && !vld_s1 && !free_ok_q) begin
				free_slot_q <= idx_s1;
			end
			if (((mode_q == SC_REM) && vld_s1 && !hit_q && (id_rd == target_q)) ||
			    ((mode_q == SC_MIN) && vld_s1 && better)) begin
				sel_slot_q <= idx_s1;
				sel_rank_q <= rk_rd;
				sel_dl_q   <= dl_rd;
				sel_id_q   <= id_rd;
			end
		end
	end

	// ceiling divide by 1e6: drop six low bits, then multiply by the
	// reciprocal of 15625 in three 15-bit slices, high slice first
	assign part   = mul_src_q[44:30] * DIV_RECIP;
	assign acc_nx = {acc_q[75:0], 15'd0} + {30'd0, part};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_chk_q  <= 1'b0;
			div_run_q  <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= (div_chk_q && (le_q || (rem_q >= DIV_LIMIT))) ||
			              (div_run_q && (cnt_q == '0));
			if (cmd_c.div_start) begin
				div_chk_q <= 1'b1;
			end else if (div_chk_q) begin
				div_chk_q <= 1'b0;
				if (!le_q && (rem_q < DIV_LIMIT)) begin
					div_run_q <= 1'b1;
				end
			end else if (div_run_q && (cnt_q == '0)) begin
				div_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.div_start) begin
			rem_q <= {1'b0, sel_dl_q} - {1'b0, now_q} + {44'd0, NS_ROUND_UP};
			le_q  <= sel_dl_q <= now_q;
		end else if (div_chk_q) begin
			cnt_q     <= 2'd2;
			mul_src_q <= rem_q[50:6];
			acc_q     <= '0;
			if (le_q) begin
				wait_q <= '0;
			end else begin
				wait_q <= {1'b0, WAIT_MAX};
			end
		end else if (div_run_q) begin
			mul_src_q <= {mul_src_q[29:0], 15'd0};
			acc_q     <= acc_nx;
			cnt_q     <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				wait_q <= {1'b0, acc_nx[89:59]};
			end
		end
	end

	// response register
	assign out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd_c.emit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.emit) begin
			last <= cmd_c.res_last;
			case (cmd_c.res_sel)
				RES_FULL: begin
					status   <= ST_FULL;
					timer_id <= '0;
					wait_ms  <= '0;
				end
				RES_ADD: begin
					status   <= ST_DONE;
					timer_id <= added_id_q;
					wait_ms  <= '0;
				end
				RES_DONE: begin
					status   <= ST_DONE;
					timer_id <= '0;
					wait_ms  <= '0;
				end
				RES_MISS: begin
					status   <= ST_NONE;
					timer_id <= '0;
					wait_ms  <= '0;
				end
				RES_EMPTY: begin
					status   <= ST_NONE;
					timer_id <= '0;
					wait_ms  <= WAIT_NONE;
				end
				RES_WAIT: begin
					status   <= ST_DONE;
					timer_id <= '0;
					wait_ms  <= wait_q;
				end
				RES_EXP: begin
					status   <= ST_EXP;
					timer_id <= pend_id_q;
					wait_ms  <= '0;
				end
				default: begin
					status   <= ST_NONE;
					timer_id <= '0;
					wait_ms  <= '0;
				end
			endcase
		end
	end

	assign sts.scan_done = done_q;
	assign sts.hit       = hit_q;
	assign sts.expired   = hit_q && (sel_dl_q <= now_q);
	assign sts.full      = count_q == CW'(CAP);
	assign sts.div_done  = div_done_q;
	assign sts.out_free  = out_free;
endmodule

FILE: rtl/core/ostq_ctrl.sv
// Command sequencer of the timer queue: accepts a word, drives the
// datapath scans and the response emission. Uses ostq_pkg.
`timescale 1ns / 1ps
module ostq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  ostq_pkg::ctl_sts_t sts,
	output ostq_pkg::ctl_cmd_t cmd_c
);
	import ostq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_IDSCAN  = 7'b0000010,
		S_REMSCAN = 7'b0000100,
		S_MINSCAN = 7'b0001000,
		S_SWEEP   = 7'b0010000,
		S_DIV     = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [1:0]      op_q;
	res_sel_t        res_q, res_d;
	logic            last_q, last_d;
	logic            take_q, take_d;
	logic [NW-1:0]   n_q, n_d;
	logic            accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		last_d  = last_q;
		take_d  = take_q;
		n_d     = n_q;
		cmd_c   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_c.load_in = 1'b1;
					n_d           = '0;
					take_d        = 1'b0;
					case (op)
						OP_ADD: begin
							if (sts.full) begin
								res_d   = RES_FULL;
								last_d  = 1'b1;
								state_d = S_EMIT;
							end else begin
								cmd_c.scan_start = 1'b1;
								cmd_c.scan_mode  = SC_ID;
								state_d          = S_IDSCAN;
							end
						end
						OP_REM: begin
							cmd_c.scan_start = 1'b1;
							cmd_c.scan_mode  = SC_REM;
							state_d          = S_REMSCAN;
						end
						default: begin
							cmd_c.scan_start = 1'b1;
							cmd_c.scan_mode  = SC_MIN;
							state_d          = S_MINSCAN;
						end
					endcase
				end
			end
			S_IDSCAN: begin
				if (sts.scan_done) begin
					if (sts.hit) begin
						cmd_c.id_adv     = 1'b1;
						cmd_c.scan_start = 1'b1;
						cmd_c.scan_mode  = SC_ID;
					end else begin
						cmd_c.add_commit = 1'b1;
						res_d            = RES_ADD;
						last_d           = 1'b1;
						state_d          = S_EMIT;
					end
				end
			end
			S_REMSCAN: begin
				if (sts.scan_done) begin
					if (sts.hit) begin
						cmd_c.free_sel   = 1'b1;
						cmd_c.scan_start = 1'b1;
						cmd_c.scan_mode  = SC_SWEEP;
						state_d          = S_SWEEP;
					end else begin
						res_d   = RES_MISS;
						last_d  = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_SWEEP: begin
				if (sts.scan_done) begin
					if (op_q == OP_REM) begin
						res_d   = RES_DONE;
						last_d  = 1'b1;
						state_d = S_EMIT;
					end else if (n_q == NW'(MAX_RESULTS)) begin
						res_d   = RES_EXP;
						last_d  = 1'b1;
						state_d = S_EMIT;
					end else begin
						cmd_c.scan_start = 1'b1;
						cmd_c.scan_mode  = SC_MIN;
						state_d          = S_MINSCAN;
					end
				end
			end
			S_MINSCAN: begin
				if (sts.scan_done) begin
					if (op_q == OP_QRY) begin
						if (sts.hit) begin
							cmd_c.div_start = 1'b1;
							state_d         = S_DIV;
						end else begin
							res_d   = RES_EMPTY;
							last_d  = 1'b1;
							state_d = S_EMIT;
						end
					end else if (sts.expired) begin
						if (n_q != '0) begin
							res_d   = RES_EXP;
							last_d  = 1'b0;
							take_d  = 1'b1;
							state_d = S_EMIT;
						end else begin
							cmd_c.free_sel   = 1'b1;
							cmd_c.scan_start = 1'b1;
							cmd_c.scan_mode  = SC_SWEEP;
							n_d              = n_q + 1'b1;
							state_d          = S_SWEEP;
						end
					end else begin
						res_d   = (n_q != '0) ? RES_EXP : RES_MISS;
						last_d  = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					res_d   = RES_WAIT;
					last_d  = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd_c.emit     = 1'b1;
					cmd_c.res_sel  = res_q;
					cmd_c.res_last = last_q;
					if (take_q) begin
						cmd_c.free_sel   = 1'b1;
						cmd_c.scan_start = 1'b1;
						cmd_c.scan_mode  = SC_SWEEP;
						n_d              = n_q + 1'b1;
						take_d           = 1'b0;
						state_d          = S_SWEEP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ADD;
			res_q   <= RES_DONE;
			last_q  <= 1'b0;
			take_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			last_q  <= last_d;
			take_q  <= take_d;
			n_q     <= n_d;
			if (accept) begin
				op_q <= op;
			end
		end
	end
endmodule

FILE: rtl/core/ostq_checker.sv
// Port-level checks of the timer queue unit, bound to the top level.
// Depends on ostq_pkg and one_shot_timer_queue_unit_defines.svh.
`timescale 1ns / 1ps
`include "one_shot_timer_queue_unit_defines.svh"
module ostq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [30:0] timer_id,
	input logic [31:0] wait_ms,
	input logic        last
);
	import ostq_pkg::*;

	`OSTQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "word taken while busy")
	`OSTQ_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(timer_id) && $stable(wait_ms) && $stable(last), "stalled word changed")
	`OSTQ_ASSERT_NOW(a_empty_word, out_valid && (wait_ms == WAIT_NONE), (status == ST_NONE) && last, "bad empty query word")
	`OSTQ_ASSERT_NOW(a_full_word, out_valid && (status == ST_FULL), last && (timer_id == '0) && (wait_ms == '0), "bad full word")
endmodule

bind one_shot_timer_queue_unit ostq_checker u_ostq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.status(rsp.status),
	.timer_id(rsp.timer_id),
	.wait_ms(rsp.wait_ms),
	.last(rsp.last)
);
